// ===== hdl/ccs_pkg.sv =====
// Package for the cyclic code set checker.
// Word sizes, register indexes, reset values and the result type.
// No dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

    localparam int WORD_BITS = 16;
    localparam int NUM_WORDS = 4;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = 2;
    localparam int FAIL_W    = 3;

    localparam logic [IDX_W-1:0] CFG_CODE_LEN    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WEIGHT_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WEIGHT_HIGH = 2'd2;

    localparam logic [LEN_W-1:0] RST_CODE_LEN    = 5'd14;
    localparam logic [LEN_W-1:0] RST_WEIGHT_LOW  = 5'd4;
    localparam logic [LEN_W-1:0] RST_WEIGHT_HIGH = 5'd6;

    localparam logic [FAIL_W-1:0] FAIL_NONE = FAIL_W'(NUM_WORDS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0] t_words;

    typedef struct packed {
        logic              accepted;
        logic              order_ok;
        logic              weight_ok;
        logic              code_ok;
        logic [FAIL_W-1:0] first_failing_word;
    } t_result;

endpackage

// ===== hdl/ccs_in_if.sv =====
// Input channel: one candidate set of four code words per beat.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

interface ccs_in_if
    import ccs_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word word_a;
    t_word word_b;
    t_word word_c;
    t_word word_new;

    modport source (output valid, word_a, word_b, word_c, word_new, input ready);
    modport sink   (input valid, word_a, word_b, word_c, word_new, output ready);
endinterface

// ===== hdl/ccs_out_if.sv =====
// Output channel: pass flags and first failing word, one beat per set.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

interface ccs_out_if
    import ccs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              order_ok;
    logic              weight_ok;
    logic              code_ok;
    logic [FAIL_W-1:0] first_failing_word;

    modport source (output valid, accepted, order_ok, weight_ok, code_ok,
                    first_failing_word, input ready);
    modport sink   (input valid, accepted, order_ok, weight_ok, code_ok,
                    first_failing_word, output ready);
endinterface

// ===== hdl/ccs_cover.sv =====
// Cyclic cover vector: bit s set when the word is covered by the pattern
// rotated left by s within the active length. Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_cover
    import ccs_pkg::*;
(
    input  t_word            i_word,
    input  t_word            i_pattern,
    input  logic [LEN_W-1:0] i_len,
    output t_word            o_cover
);

    logic [WORD_BITS:0]   mask_full;
    t_word                mask;

    assign mask_full = (17'd1 << i_len) - 17'd1;
    assign mask      = mask_full[WORD_BITS-1:0];

    for (genvar s = 0; s < WORD_BITS; s++) begin : g_rot
        logic [LEN_W-1:0] sh;
        t_word            rot;

        assign sh  = i_len - LEN_W'(s);
        assign rot = ((i_pattern << s) | (i_pattern >> sh)) & mask;
        assign o_cover[s] = (LEN_W'(s) < i_len) && ((i_word & ~rot) == '0);
    end

endmodule

// ===== hdl/cyclic_code_set_checker.sv =====
// Cyclic code set checker, top level.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if and ccs_cover.
//
// Use: each beat on i_in carries word_a, word_b, word_c and word_new. One
// result beat per input beat leaves on o_out, in order: order, weight and
// code pass flags, their AND, and the lowest word index failing the cyclic
// cover tests (4 when none fails).
// Configuration: i_cfg_we with i_cfg_idx (0 code length, 1 weight_low,
// 2 weight_high, 3 ignored) and i_cfg_data; write only while idle.
// Path: the input beat is captured in the input register, then its result
// in the result register, which drives o_out.
// Throughput: one set per cycle while o_out.ready is high, set by the single
// pass of cover logic between the two registers.
// Stall: when o_out.ready is low the result holds and the input register
// still fills; i_in.ready drops only once both stages are full.
// Reset: i_rst_n synchronous, active low; both stages empty, registers
// return to code length 14, weight_low 4, weight_high 6.
`timescale 1ns / 1ps

module cyclic_code_set_checker
    import ccs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    ccs_in_if.sink           i_in,
    ccs_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_code_len;
    logic [LEN_W-1:0] r_weight_low;
    logic [LEN_W-1:0] r_weight_high;

    logic    r_v1;
    logic    r_v2;
    t_words  r_w;
    t_result r_res;
    t_result n_res;

    logic en1;
    logic en2;

    logic [LEN_W-1:0]     len;
    t_word                all_or;
    t_words               others;
    t_words               cov_all;
    t_words               cov_oth;
    logic [NUM_WORDS-1:0] pass;
    logic [LEN_W-1:0]     pc;
    logic [WORD_BITS:0]   lim;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_len    <= RST_CODE_LEN;
            r_weight_low  <= RST_WEIGHT_LOW;
            r_weight_high <= RST_WEIGHT_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CODE_LEN:    r_code_len    <= i_cfg_data;
                CFG_WEIGHT_LOW:  r_weight_low  <= i_cfg_data;
                CFG_WEIGHT_HIGH: r_weight_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en2 = !r_v2 || o_out.ready;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in.valid) begin
            r_w <= {i_in.word_new, i_in.word_c, i_in.word_b, i_in.word_a};
        end
        if (en2 && r_v1) begin
            r_res <= n_res;
        end
    end

    assign len = (r_code_len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : r_code_len;

    always_comb begin
        all_or = '0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            all_or = all_or | r_w[k];
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            others[k] = '0;
            for (int j = 0; j < NUM_WORDS; j++) begin
                if (j != k) others[k] = others[k] | r_w[j];
            end
        end
    end

    for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
        ccs_cover u_cov_all (
            .i_word    (r_w[k]),
            .i_pattern (all_or),
            .i_len     (len),
            .o_cover   (cov_all[k])
        );
        ccs_cover u_cov_oth (
            .i_word    (r_w[k]),
            .i_pattern (others[k]),
            .i_len     (len),
            .o_cover   (cov_oth[k])
        );
        assign pass[k] = (cov_all[k] == t_word'(1)) && (cov_oth[k] == '0);
    end

    assign pc  = LEN_W'($countones(r_w[NUM_WORDS-1]));
    assign lim = 17'd1 << len;

    always_comb begin
        n_res = '0;
        n_res.order_ok  = (r_w[3] > r_w[2]) && ({1'b0, r_w[3]} < lim);
        n_res.weight_ok = (pc >= r_weight_low) && (pc <= r_weight_high);
        if (!pass[0])      n_res.first_failing_word = 3'd0;
        else if (!pass[1]) n_res.first_failing_word = 3'd1;
        else if (!pass[2]) n_res.first_failing_word = 3'd2;
        else if (!pass[3]) n_res.first_failing_word = 3'd3;
        else               n_res.first_failing_word = FAIL_NONE;
        n_res.code_ok  = &pass;
        n_res.accepted = n_res.order_ok && n_res.weight_ok && n_res.code_ok;
    end

    assign o_out.valid              = r_v2;
    assign o_out.accepted           = r_res.accepted;
    assign o_out.order_ok           = r_res.order_ok;
    assign o_out.weight_ok          = r_res.weight_ok;
    assign o_out.code_ok            = r_res.code_ok;
    assign o_out.first_failing_word = r_res.first_failing_word;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v2 |-> i_in.ready)
        else $error("input stalled with empty result stage");

    a_code_vs_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.code_ok == (o_out.first_failing_word == FAIL_NONE)))
        else $error("code_ok disagrees with first failing word");

    a_accepted_and: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.accepted ==
                         (o_out.order_ok && o_out.weight_ok && o_out.code_ok)))
        else $error("accepted is not the AND of the pass flags");

endmodule

// ===== sim/cyclic_code_set_checker_test.sv =====
// Self-checking testbench for cyclic_code_set_checker: directed, register-extreme,
// input-stall and random candidate sets checked against an in-bench verdict model.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if and the block under test.
`timescale 1ns / 1ps

module cyclic_code_set_checker_test;
    import ccs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_IDLE     = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_CAP    = 40;
    localparam int RETRY_LIMIT  = 40;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        MUT_SWAP_TAIL,
        MUT_COPY_WORD,
        MUT_TIE_TAIL,
        MUT_ROTATE_COPY,
        MUT_HIGH_BIT
    } t_mutation;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [LEN_W-1:0] cfg_data;

    ccs_in_if  in_ch ();
    ccs_out_if out_ch ();

    cyclic_code_set_checker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [LEN_W-1:0] shadow_len = RST_CODE_LEN;
    logic [LEN_W-1:0] shadow_wlo = RST_WEIGHT_LOW;
    logic [LEN_W-1:0] shadow_whi = RST_WEIGHT_HIGH;

    t_result verdict_q[$];
    t_result want_verdict;

    int errors        = 0;
    int sets_sent     = 0;
    int verdicts_seen = 0;
    int accepts_seen  = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned eff_len();
        return (shadow_len > WORD_BITS) ? WORD_BITS : shadow_len;
    endfunction

    // bit s set when w is covered by x rotated left by s
    function automatic logic [WORD_BITS-1:0] rotation_hits(logic [31:0] w, logic [31:0] x,
                                                         int unsigned len);
        logic [31:0]          m;
        logic [31:0]          r;
        logic [WORD_BITS-1:0] hits;
        int unsigned          s;
        m    = (32'd1 << len) - 32'd1;
        hits = '0;
        for (s = 0; s < len; s++) begin
            r = ((x << s) | (x >> (len - s))) & m;
            if ((w & ~r) == 32'd0) begin
                hits[s] = 1'b1;
            end
        end
        return hits;
    endfunction

    function automatic t_result compute_verdict(t_words ws);
        int unsigned len;
        int unsigned pc;
        int unsigned first;
        int unsigned k;
        int unsigned j;
        logic [31:0] all_or;
        logic [31:0] others;
        t_result     v;
        len    = eff_len();
        all_or = 32'(ws[0] | ws[1] | ws[2] | ws[3]);
        v.order_ok  = (ws[3] > ws[2]) && ({16'd0, ws[3]} < (32'd1 << len));
        pc          = $countones(ws[3]);
        v.weight_ok = (pc >= shadow_wlo) && (pc <= shadow_whi);
        first = NUM_WORDS;
        for (k = 0; k < NUM_WORDS && first == NUM_WORDS; k++) begin
            others = '0;
            for (j = 0; j < NUM_WORDS; j++) begin
                if (j != k) begin
                    others |= 32'(ws[j]);
                end
            end
            if (rotation_hits(32'(ws[k]), all_or, len) != 16'd1 ||
                rotation_hits(32'(ws[k]), others, len) != 16'd0) begin
                first = k;
            end
        end
        v.code_ok            = (first == NUM_WORDS);
        v.accepted           = v.order_ok && v.weight_ok && v.code_ok;
        v.first_failing_word = FAIL_W'(first);
        return v;
    endfunction

    // ------------------------------------------------------------- stimulus

    function automatic t_word weighted_word(int unsigned len);
        int unsigned lo;
        int unsigned hi;
        int unsigned wt;
        t_word       v;
        lo = (shadow_wlo < len) ? shadow_wlo : len;
        hi = (shadow_whi < len) ? shadow_whi : len;
        if (lo > hi) begin
            lo = 0;
            hi = len;
        end
        wt = $urandom_range(hi, lo);
        v  = '0;
        while ($countones(v) < wt) begin
            v[$urandom_range(len - 1, 0)] = 1'b1;
        end
        return v;
    endfunction

    // well-formed set inside the current length; with want_pass, retries towards a code that passes
    function automatic t_words make_set(bit want_pass);
        t_words      ws;
        t_result     v;
        t_word       tmp;
        int unsigned len;
        int unsigned tries;
        int unsigned k;
        len = eff_len();
        ws  = '0;
        if (len == 0) begin
            return ws;
        end
        tries = want_pass ? RETRY_LIMIT : 1;
        do begin
            for (k = 0; k < NUM_WORDS; k++) begin
                ws[k] = weighted_word(len);
            end
            if (ws[3] < ws[2]) begin
                tmp   = ws[3];
                ws[3] = ws[2];
                ws[2] = tmp;
            end
            tries--;
            v = compute_verdict(ws);
        end while (tries > 0 && !v.code_ok);
        return ws;
    endfunction

    function automatic t_words broken_set();
        t_words      ws;
        t_word       tmp;
        int unsigned len;
        int unsigned s;
        int unsigned i;
        int unsigned j;
        len = eff_len();
        ws  = make_set(1'b1);
        i   = $urandom_range(NUM_WORDS - 1, 0);
        j   = (i + $urandom_range(NUM_WORDS - 1, 1)) % NUM_WORDS;
        case (t_mutation'($urandom_range(MUT_HIGH_BIT, MUT_SWAP_TAIL)))
            MUT_SWAP_TAIL: begin
                tmp   = ws[3];
                ws[3] = ws[2];
                ws[2] = tmp;
            end
            MUT_COPY_WORD: ws[j] = ws[i];
            MUT_TIE_TAIL:  ws[3] = ws[2];
            MUT_ROTATE_COPY: begin
                if (len > 0) begin
                    s     = $urandom_range(len - 1, 0);
                    ws[j] = WORD_BITS'(((32'(ws[i]) << s) | (32'(ws[i]) >> (len - s)))
                                       & ((32'd1 << len) - 32'd1));
                end
            end
            default: begin
                if (len < WORD_BITS) begin
                    ws[i][$urandom_range(WORD_BITS - 1, len)] = 1'b1;
                end else begin
                    ws[i] = ~ws[i];
                end
            end
        endcase
        return ws;
    endfunction

    function automatic t_words random_item();
        int unsigned pick;
        t_words      ws;
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
            ws = make_set(pick < 55);
        end else if (pick < 88) begin
            ws = broken_set();
        end else begin
            ws = {$urandom, $urandom};
        end
        return ws;
    endfunction

    // ------------------------------------------------------------ channels

    task automatic send_set(t_words ws);
        int gap;
        gap = tx_idle ? $urandom_range(MAX_IDLE, 0) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.word_a   <= ws[0];
        in_ch.word_b   <= ws[1];
        in_ch.word_c   <= ws[2];
        in_ch.word_new <= ws[3];
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        verdict_q = {verdict_q, compute_verdict(ws)};
        sets_sent++;
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CODE_LEN:    shadow_len = data;
            CFG_WEIGHT_LOW:  shadow_wlo = data;
            CFG_WEIGHT_HIGH: shadow_whi = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned bl, int unsigned wl, int unsigned wh);
        drain_pipeline();
        write_reg(CFG_CODE_LEN, LEN_W'(bl));
        write_reg(CFG_WEIGHT_LOW, LEN_W'(wl));
        write_reg(CFG_WEIGHT_HIGH, LEN_W'(wh));
        write_reg(CFG_UNUSED, LEN_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] result %0d: %s", $time, verdicts_seen, what);
        end
    endtask

    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(MAX_IDLE, 0) : 0;
            if (gap > 0 || rx_hold) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with no set pending");
            end else begin
                want_verdict = verdict_q.pop_front();
                if (want_verdict.accepted) accepts_seen++;
                if (out_ch.accepted !== want_verdict.accepted)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              out_ch.accepted, want_verdict.accepted));
                if (out_ch.order_ok !== want_verdict.order_ok)
                    report_mismatch($sformatf("order_ok %b, want %b",
                                              out_ch.order_ok, want_verdict.order_ok));
                if (out_ch.weight_ok !== want_verdict.weight_ok)
                    report_mismatch($sformatf("weight_ok %b, want %b",
                                              out_ch.weight_ok, want_verdict.weight_ok));
                if (out_ch.code_ok !== want_verdict.code_ok)
                    report_mismatch($sformatf("code_ok %b, want %b",
                                              out_ch.code_ok, want_verdict.code_ok));
                if (out_ch.first_failing_word !== want_verdict.first_failing_word)
                    report_mismatch($sformatf("first_failing_word %0d, want %0d",
                                              out_ch.first_failing_word,
                                              want_verdict.first_failing_word));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, verdict_q.size());
        $display("cyclic_code_set_checker_test: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // reset settings: length 14, weight 4..6
    task automatic test_directed();
        t_words good;
        t_words ws;
        send_set('0);
        send_set({NUM_WORDS{16'hFFFF}});
        good = make_set(1'b1);
        send_set(good);
        ws = good; ws[2] = good[3]; ws[3] = good[2];
        send_set(ws);
        ws = good; ws[3] = ws[2];
        send_set(ws);
        ws = good; ws[3] = 16'h3FFF;
        send_set(ws);
        ws = good; ws[3] = 16'h4000;
        send_set(ws);
        ws = good; ws[2] = 16'h0000; ws[3] = 16'hFFFF;
        send_set(ws);
        ws = good; ws[2] = 16'hFFFF; ws[3] = 16'h0000;
        send_set(ws);
        ws = good; ws[2] = 16'h0000; ws[3] = 16'h0007;
        send_set(ws);
        ws[3] = 16'h000F;
        send_set(ws);
        ws[3] = 16'h003F;
        send_set(ws);
        ws[3] = 16'h007F;
        send_set(ws);
        ws = good; ws[0] = ws[0] | 16'h8000;
        send_set(ws);
        ws = good; ws[1] = ws[0];
        send_set(ws);
        ws = good; ws[3] = ws[1];
        send_set(ws);
        ws = good; ws[1] = {2'b00, ws[0][12:0], ws[0][13]};
        send_set(ws);
        ws = good; ws[0] = '0;
        send_set(ws);
        ws = good; ws[2] = 16'h1000; ws[3] = 16'h2000;
        send_set(ws);
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        int unsigned bl_set[9] = '{0, 1, 2, 16, 17, 31, 14, 14, 8};
        int unsigned wl_set[9] = '{0, 0, 1, 4, 0, 31, 6, 0, 16};
        int unsigned wh_set[9] = '{0, 1, 2, 6, 16, 31, 4, 31, 0};
        int          p;
        for (p = 0; p < 9; p++) begin
            apply_settings(bl_set[p], wl_set[p], wh_set[p]);
            repeat (25) send_set(random_item());
        end
        drain_pipeline();
    endtask

    task automatic test_input_stall();
        apply_settings(12, 3, 5);
        tx_idle = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (40) send_set(random_item());
        drain_pipeline();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_sets();
        int unsigned wl;
        int          p;
        for (p = 0; p < 6; p++) begin
            wl = $urandom_range(5, 0);
            apply_settings($urandom_range(WORD_BITS, 2), wl, wl + $urandom_range(4, 0));
            tx_idle = ($urandom_range(3, 0) != 0);
            rx_idle = ($urandom_range(3, 0) != 0);
            repeat (140) send_set(random_item());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain_pipeline();
    endtask

    initial begin
        in_ch.valid    <= 1'b0;
        in_ch.word_a   <= '0;
        in_ch.word_b   <= '0;
        in_ch.word_c   <= '0;
        in_ch.word_new <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_input_stall();
        test_random_sets();
        drain_pipeline();

        $display("sent %0d candidate sets over %0d register settings plus reset values;",
                 sets_sent, settings_used);
        $display("checked %0d results, %0d accepted, with idle gaps and a long output stall",
                 verdicts_seen, accepts_seen);
        if (errors == 0) begin
            $display("cyclic_code_set_checker_test: done, clean");
        end else begin
            $display("cyclic_code_set_checker_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ccs_pkg.sv
hdl/ccs_in_if.sv
hdl/ccs_out_if.sv
hdl/ccs_cover.sv
hdl/cyclic_code_set_checker.sv
sim/cyclic_code_set_checker_test.sv
